// File: hw/rtl/mdbrd_pkg.sv
// ----------------------------------------------------------------------------
// mdbrd_pkg
// Types and constants shared by the bus response deframer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package mdbrd_pkg;

   // request type codes on the input channel
   localparam logic [1:0] REQ_WORD     = 2'd0;
   localparam logic [1:0] REQ_LINE_ERR = 2'd1;
   localparam logic [1:0] REQ_TIMEOUT  = 2'd2;

   // frame status codes on the result channel
   localparam logic [3:0] ST_BUSY       = 4'd0;
   localparam logic [3:0] ST_OK         = 4'd1;
   localparam logic [3:0] ST_ACK        = 4'd2;
   localparam logic [3:0] ST_NAK        = 4'd3;
   localparam logic [3:0] ST_OTHER      = 4'd4;
   localparam logic [3:0] ST_BADSUM     = 4'd5;
   localparam logic [3:0] ST_LINEERR    = 4'd6;
   localparam logic [3:0] ST_NONE       = 4'd7;
   localparam logic [3:0] ST_INCOMPLETE = 4'd8;
   localparam logic [3:0] ST_OVERFLOW   = 4'd9;

   // configuration registers (byte address 4*index)
   localparam int unsigned CSR_ADDR_W = 3;
   localparam logic        CSR_ACK_CODE = 1'b0;
   localparam logic        CSR_NAK_CODE = 1'b1;
   localparam logic [8:0]  ACK_CODE_RESET = 9'h100;
   localparam logic [8:0]  NAK_CODE_RESET = 9'h1FF;

   // mode bit of a received word
   localparam int unsigned MODE_BIT = 8;

   // front-to-back queue
   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // what the front decided about a beat
   typedef enum logic [2:0] {
      KIND_DATA,
      KIND_MODE,
      KIND_LINE_ERR,
      KIND_TIMEOUT,
      KIND_IGNORE
   } kind_type;

   typedef struct packed {
      kind_type   kind;
      logic [8:0] word;
      logic       is_ack;
      logic       is_nak;
   } item_type;

endpackage : mdbrd_pkg

`default_nettype wire

// File: hw/rtl/mdb_response_deframer.sv
// ----------------------------------------------------------------------------
// mdb_response_deframer
// Deframes one multi-drop bus response: passes payload bytes, checks the
// checksum and reports how each frame ended.
// ----------------------------------------------------------------------------
// One result beat comes out for every request beat, in order. The block takes
// one beat per clock while the queue is not full: a classified beat waits in a
// two-entry queue and the back end retires one per cycle into the result
// register when the result side is not stalled, so a request passes through a
// queue entry and then the result register before its result is presented. A
// stall on the result side fills the queue and then raises req_stall; throughput
// is one beat per cycle when the result side does not stall, limited by the
// single result register. The ack and nak codes are written over APB at byte
// addresses 0x0 and 0x4 and should only change while no beat is in flight.
`default_nettype none

module mdb_response_deframer #(
   parameter int unsigned MAX_PAYLOAD = 36
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   // APB register port
   input  wire logic                             psel,
   input  wire logic                             penable,
   input  wire logic                             pwrite,
   input  wire logic [mdbrd_pkg::CSR_ADDR_W-1:0] paddr,
   input  wire logic [31:0]                      pwdata,
   output logic [31:0]                           prdata,
   output logic                                  pready,
   // request channel
   input  wire logic                             req_valid,
   output logic                                  req_stall,
   input  wire logic [1:0]                       req_type,
   input  wire logic [8:0]                       req_rx_word,
   // result channel
   output logic                                  rsp_valid,
   input  wire logic                             rsp_stall,
   output logic                                  rsp_data_valid,
   output logic [7:0]                            rsp_data_byte,
   output logic                                  rsp_frame_done,
   output logic [3:0]                            rsp_frame_status,
   output logic [5:0]                            rsp_byte_count
);

   mdbrd_pkg::item_type front_item;
   mdbrd_pkg::item_type head_item;
   logic                q_full;
   logic                head_valid;
   logic                pop;

   assign req_stall = q_full;

   // front: registers and classification
   mdbrd_front u_front (
      .clock       (clock),
      .reset       (reset),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .prdata      (prdata),
      .pready      (pready),
      .req_type    (req_type),
      .req_rx_word (req_rx_word),
      .item        (front_item)
   );

   // queue between front and back
   mdbrd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (req_valid),
      .push_item  (front_item),
      .full       (q_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_item  (head_item)
   );

   // back: frame state and results
   mdbrd_back #(
      .MAX_PAYLOAD (MAX_PAYLOAD)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .head_valid       (head_valid),
      .head_item        (head_item),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data_valid   (rsp_data_valid),
      .rsp_data_byte    (rsp_data_byte),
      .rsp_frame_done   (rsp_frame_done),
      .rsp_frame_status (rsp_frame_status),
      .rsp_byte_count   (rsp_byte_count)
   );

   // a beat that ends a frame never carries payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_done |-> !rsp_data_valid)
      else $error("frame end beat carries payload");

   // busy status only on beats that do not end the frame
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_done |-> rsp_frame_status != mdbrd_pkg::ST_BUSY)
      else $error("frame end reported as busy");

   // reported count stays within the payload buffer
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_byte_count <= 6'(MAX_PAYLOAD))
      else $error("byte count beyond buffer size");

   // a payload beat always has a nonzero count
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data_valid |-> rsp_byte_count != 6'd0)
      else $error("payload beat with zero count");

endmodule : mdb_response_deframer

`default_nettype wire

// File: hw/rtl/mdbrd_front.sv
// ----------------------------------------------------------------------------
// mdbrd_front
// Holds the ack/nak code registers behind the APB port and classifies each
// incoming beat into a queue entry.
// ----------------------------------------------------------------------------
`default_nettype none

module mdbrd_front (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   // APB register port
   input  wire logic                                 psel,
   input  wire logic                                 penable,
   input  wire logic                                 pwrite,
   input  wire logic [mdbrd_pkg::CSR_ADDR_W-1:0]     paddr,
   input  wire logic [31:0]                          pwdata,
   output logic [31:0]                               prdata,
   output logic                                      pready,
   // incoming beat
   input  wire logic [1:0]                           req_type,
   input  wire logic [8:0]                           req_rx_word,
   output mdbrd_pkg::item_type                       item
);

   logic [8:0] ack_code_ff;
   logic [8:0] ack_code_in;
   logic [8:0] nak_code_ff;
   logic [8:0] nak_code_in;
   logic       wr_en;
   logic       reg_sel;

   assign pready  = 1'b1;
   assign wr_en   = psel & penable & pwrite & pready;
   assign reg_sel = paddr[2];

   // register writes
   always_comb begin
      ack_code_in = ack_code_ff;
      nak_code_in = nak_code_ff;
      if (wr_en) begin
         if (reg_sel == mdbrd_pkg::CSR_ACK_CODE) begin
            ack_code_in = pwdata[8:0];
         end else begin
            nak_code_in = pwdata[8:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ack_code_ff <= mdbrd_pkg::ACK_CODE_RESET;
         nak_code_ff <= mdbrd_pkg::NAK_CODE_RESET;
      end else begin
         ack_code_ff <= ack_code_in;
         nak_code_ff <= nak_code_in;
      end
   end

   // register read
   always_comb begin
      if (reg_sel == mdbrd_pkg::CSR_ACK_CODE) begin
         prdata = {23'd0, ack_code_ff};
      end else begin
         prdata = {23'd0, nak_code_ff};
      end
   end

   // classify the beat and flag matches with both codes; the back end lets ack win
   always_comb begin
      item.word   = req_rx_word;
      item.is_ack = (req_rx_word == ack_code_ff);
      item.is_nak = (req_rx_word == nak_code_ff);
      case (req_type)
         mdbrd_pkg::REQ_WORD: begin
            item.kind = req_rx_word[mdbrd_pkg::MODE_BIT] ? mdbrd_pkg::KIND_MODE
                                                          : mdbrd_pkg::KIND_DATA;
         end
         mdbrd_pkg::REQ_LINE_ERR: item.kind = mdbrd_pkg::KIND_LINE_ERR;
         mdbrd_pkg::REQ_TIMEOUT:  item.kind = mdbrd_pkg::KIND_TIMEOUT;
         default:                 item.kind = mdbrd_pkg::KIND_IGNORE;
      endcase
   end

endmodule : mdbrd_front

`default_nettype wire

// File: hw/rtl/mdbrd_queue.sv
// ----------------------------------------------------------------------------
// mdbrd_queue
// Short FIFO of classified beats between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module mdbrd_queue (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push,
   input  wire mdbrd_pkg::item_type  push_item,
   output logic                      full,
   input  wire logic                 pop,
   output logic                      head_valid,
   output mdbrd_pkg::item_type       head_item
);

   localparam int unsigned DEPTH = mdbrd_pkg::QUEUE_DEPTH;
   localparam int unsigned PW    = mdbrd_pkg::QPTR_W;
   localparam int unsigned CW    = mdbrd_pkg::QCNT_W;

   mdbrd_pkg::item_type mem_ff [DEPTH];
   logic [PW-1:0]       wr_ptr_ff;
   logic [PW-1:0]       wr_ptr_in;
   logic [PW-1:0]       rd_ptr_ff;
   logic [PW-1:0]       rd_ptr_in;
   logic [CW-1:0]       count_ff;
   logic [CW-1:0]       count_in;
   logic                do_push;
   logic                do_pop;

   assign full       = (count_ff == CW'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_item  = mem_ff[rd_ptr_ff];
   assign do_push    = push & ~full;
   assign do_pop     = pop & head_valid;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule : mdbrd_queue

`default_nettype wire

// File: hw/rtl/mdbrd_back.sv
// ----------------------------------------------------------------------------
// mdbrd_back
// Carries out one queued beat per cycle while the result register is free or
// draining: keeps the frame checksum and byte count, decides the frame status and
// drives the result register.
`default_nettype none

module mdbrd_back #(
   parameter int unsigned MAX_PAYLOAD = 36
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 head_valid,
   input  wire mdbrd_pkg::item_type  head_item,
   output logic                      pop,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic                      rsp_data_valid,
   output logic [7:0]                rsp_data_byte,
   output logic                      rsp_frame_done,
   output logic [3:0]                rsp_frame_status,
   output logic [5:0]                rsp_byte_count
);

   localparam logic [5:0] MAX_COUNT = 6'(MAX_PAYLOAD);

   logic [7:0] sum_ff;
   logic [7:0] sum_in;
   logic [5:0] count_ff;
   logic [5:0] count_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   logic       data_valid_ff;
   logic       data_valid_in;
   logic [7:0] data_byte_ff;
   logic [7:0] data_byte_in;
   logic       done_ff;
   logic       done_in;
   logic [3:0] status_ff;
   logic [3:0] status_in;
   logic [5:0] byte_count_ff;
   logic [5:0] byte_count_in;

   // take a beat whenever the result register is free or being drained
   assign pop = head_valid & (~rsp_valid_ff | ~rsp_stall);

   // frame logic for the beat at the head of the queue
   always_comb begin
      sum_in        = sum_ff;
      count_in      = count_ff;
      data_valid_in = 1'b0;
      data_byte_in  = 8'd0;
      done_in       = 1'b0;
      status_in     = mdbrd_pkg::ST_BUSY;
      byte_count_in = count_ff;
      case (head_item.kind)
         mdbrd_pkg::KIND_DATA: begin
            if (count_ff >= MAX_COUNT) begin
               done_in   = 1'b1;
               status_in = mdbrd_pkg::ST_OVERFLOW;
               sum_in    = 8'd0;
               count_in  = 6'd0;
            end else begin
               data_valid_in = 1'b1;
               data_byte_in  = head_item.word[7:0];
               sum_in        = sum_ff + head_item.word[7:0];
               count_in      = count_ff + 6'd1;
               byte_count_in = count_ff + 6'd1;
            end
         end
         mdbrd_pkg::KIND_MODE: begin
            done_in = 1'b1;
            if (count_ff == 6'd0) begin
               // control word on an empty frame
               if (head_item.is_ack) begin
                  status_in = mdbrd_pkg::ST_ACK;
               end else if (head_item.is_nak) begin
                  status_in = mdbrd_pkg::ST_NAK;
               end else begin
                  status_in = mdbrd_pkg::ST_OTHER;
               end
            end else begin
               // checksum word closes a data frame
               status_in = (head_item.word[7:0] == sum_ff) ? mdbrd_pkg::ST_OK
                                                           : mdbrd_pkg::ST_BADSUM;
            end
            sum_in   = 8'd0;
            count_in = 6'd0;
         end
         mdbrd_pkg::KIND_LINE_ERR: begin
            done_in   = 1'b1;
            status_in = mdbrd_pkg::ST_LINEERR;
            sum_in    = 8'd0;
            count_in  = 6'd0;
         end
         mdbrd_pkg::KIND_TIMEOUT: begin
            done_in   = 1'b1;
            status_in = (count_ff == 6'd0) ? mdbrd_pkg::ST_NONE : mdbrd_pkg::ST_INCOMPLETE;
            sum_in    = 8'd0;
            count_in  = 6'd0;
         end
         default: begin
            // unknown request: busy result, state unchanged
         end
      endcase
   end

   // result valid follows pop and drain
   always_comb begin
      if (pop) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff       <= 8'd0;
         count_ff     <= 6'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (pop) begin
            sum_ff   <= sum_in;
            count_ff <= count_in;
         end
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (pop) begin
         data_valid_ff <= data_valid_in;
         data_byte_ff  <= data_byte_in;
         done_ff       <= done_in;
         status_ff     <= status_in;
         byte_count_ff <= byte_count_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_data_valid   = data_valid_ff;
   assign rsp_data_byte    = data_byte_ff;
   assign rsp_frame_done   = done_ff;
   assign rsp_frame_status = status_ff;
   assign rsp_byte_count   = byte_count_ff;

endmodule : mdbrd_back

`default_nettype wire

// File: tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench for the bus response deframer.
// ----------------------------------------------------------------------------
// Directed frames cover the ack, nak and other-control classes, good and bad
// checksums, line errors, timeouts, ignored request types and buffer
// overflow. Random frames follow under three idling mixes, with the ack and
// nak codes rewritten over APB between phases. One long result-side hold-off
// fills the block so that it stalls its input. A predictor kept in this file
// works out each response beat. A checker compares every response beat, in
// order, with the one predicted for it.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int unsigned MAX_BYTES   = 36;
   localparam int unsigned CYCLE_LIMIT = 200000;
   localparam int unsigned PHASE_BEATS = 110;
   localparam logic [mdbrd_pkg::CSR_ADDR_W-1:0] ADDR_ACK = {mdbrd_pkg::CSR_ACK_CODE, 2'b00};
   localparam logic [mdbrd_pkg::CSR_ADDR_W-1:0] ADDR_NAK = {mdbrd_pkg::CSR_NAK_CODE, 2'b00};
   // request type that the block ignores
   localparam logic [1:0] REQ_UNUSED = 2'd3;

   typedef struct packed {
      logic       data_valid;
      logic [7:0] data_byte;
      logic       frame_done;
      logic [3:0] frame_status;
      logic [5:0] byte_count;
   } response_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [mdbrd_pkg::CSR_ADDR_W-1:0] paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;
   logic        req_valid;
   logic        req_stall;
   logic [1:0]  req_type;
   logic [8:0]  req_rx_word;
   logic        rsp_valid;
   logic        rsp_stall;
   logic        rsp_data_valid;
   logic [7:0]  rsp_data_byte;
   logic        rsp_frame_done;
   logic [3:0]  rsp_frame_status;
   logic [5:0]  rsp_byte_count;

   // predictor state: register copies and the frame in progress
   logic [8:0] ack_word;
   logic [8:0] nak_word;
   logic [7:0] frame_sum;
   logic [5:0] frame_count;

   response_type pending_responses[$];
   int        error_count = 0;
   int        beats_sent  = 0;
   int        cycle_count = 0;
   int        req_idle_pct = 0;
   int        rsp_idle_pct = 0;
   // long result-side hold-off, requested by the test and counted below
   int        hold_token = 0;
   int        hold_len   = 0;
   int        hold_seen  = 0;
   int        hold_left  = 0;

   mdb_response_deframer dut (
      .clock            (clock),
      .reset            (reset),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_type         (req_type),
      .req_rx_word      (req_rx_word),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data_valid   (rsp_data_valid),
      .rsp_data_byte    (rsp_data_byte),
      .rsp_frame_done   (rsp_frame_done),
      .rsp_frame_status (rsp_frame_status),
      .rsp_byte_count   (rsp_byte_count)
   );

   always #5 clock = ~clock;

   // predicted response for one accepted request beat; advances the frame
   function automatic response_type deframe_beat(input logic [1:0] kind,
                                                 input logic [8:0] word);
      response_type r;
      r = '0;
      r.frame_status = mdbrd_pkg::ST_BUSY;
      r.byte_count   = frame_count;
      case (kind)
         mdbrd_pkg::REQ_WORD: begin
            if (!word[mdbrd_pkg::MODE_BIT]) begin
               if (frame_count >= MAX_BYTES) begin
                  // buffer full: byte dropped, frame ends
                  r.frame_done   = 1'b1;
                  r.frame_status = mdbrd_pkg::ST_OVERFLOW;
                  frame_sum      = '0;
                  frame_count    = '0;
               end else begin
                  r.data_valid = 1'b1;
                  r.data_byte  = word[7:0];
                  frame_sum    = frame_sum + word[7:0];
                  frame_count  = frame_count + 6'd1;
                  r.byte_count = frame_count;
               end
            end else begin
               r.frame_done = 1'b1;
               if (frame_count == 6'd0) begin
                  // first word: classify, ack wins over nak
                  if (word == ack_word)
                     r.frame_status = mdbrd_pkg::ST_ACK;
                  else if (word == nak_word)
                     r.frame_status = mdbrd_pkg::ST_NAK;
                  else
                     r.frame_status = mdbrd_pkg::ST_OTHER;
               end else begin
                  r.frame_status = (word[7:0] == frame_sum) ? mdbrd_pkg::ST_OK
                                                            : mdbrd_pkg::ST_BADSUM;
               end
               frame_sum   = '0;
               frame_count = '0;
            end
         end
         mdbrd_pkg::REQ_LINE_ERR: begin
            r.frame_done   = 1'b1;
            r.frame_status = mdbrd_pkg::ST_LINEERR;
            frame_sum      = '0;
            frame_count    = '0;
         end
         mdbrd_pkg::REQ_TIMEOUT: begin
            r.frame_done   = 1'b1;
            r.frame_status = (frame_count == 6'd0) ? mdbrd_pkg::ST_NONE
                                                   : mdbrd_pkg::ST_INCOMPLETE;
            frame_sum      = '0;
            frame_count    = '0;
         end
         default: begin
         end
      endcase
      return r;
   endfunction

   task automatic report(input string what, input response_type want,
                         input response_type got);
      error_count++;
      if (error_count <= 10)
         $display({"ERROR @%0t %s: exp dv=%0d byte=%02h done=%0d st=%0d cnt=%0d,",
                   " got dv=%0d byte=%02h done=%0d st=%0d cnt=%0d"},
                  $time, what, want.data_valid, want.data_byte, want.frame_done,
                  want.frame_status, want.byte_count, got.data_valid, got.data_byte,
                  got.frame_done, got.frame_status, got.byte_count);
   endtask

   // result-side stall: random, or held high for a requested stretch
   always @(posedge clock) begin
      if (hold_token != hold_seen) begin
         hold_seen <= hold_token;
         hold_left <= hold_len;
         rsp_stall <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
      end
   end

   // response checker
   always @(posedge clock) begin
      response_type got;
      response_type want;
      got = {rsp_data_valid, rsp_data_byte, rsp_frame_done, rsp_frame_status, rsp_byte_count};
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_responses.size() == 0) begin
            report("response with none expected", '0, got);
         end else begin
            want = pending_responses.pop_front();
            if (got !== want)
               report("response mismatch", want, got);
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // one request beat, with a random gap ahead of it; valid stays up after
   task automatic send_beat(input logic [1:0] kind, input logic [8:0] word);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_type    <= kind;
      req_rx_word <= word;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_responses.push_back(deframe_beat(kind, word));
      if (kind != REQ_UNUSED)
         beats_sent++;
   endtask

   // drop valid and wait until every predicted response has come back
   task automatic wait_idle();
      if (req_valid)
         req_valid <= 1'b0;
      while (pending_responses.size() != 0) @(posedge clock);
   endtask

   task automatic csr_write(input logic [mdbrd_pkg::CSR_ADDR_W-1:0] addr,
                            input logic [8:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= {23'd0, value};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      if (addr == ADDR_ACK)
         ack_word = value;
      else
         nak_word = value;
      @(posedge clock);
   endtask

   task automatic csr_check(input logic [mdbrd_pkg::CSR_ADDR_W-1:0] addr,
                            input logic [8:0] want);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= addr;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      if (prdata[8:0] !== want) begin
         error_count++;
         if (error_count <= 10)
            $display("ERROR @%0t register %0h: exp %03h, got %03h",
                     $time, addr, want, prdata[8:0]);
      end
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_codes(input logic [8:0] ack, input logic [8:0] nak);
      wait_idle();
      csr_write(ADDR_ACK, ack);
      csr_write(ADDR_NAK, nak);
      csr_check(ADDR_ACK, ack);
      csr_check(ADDR_NAK, nak);
   endtask

   // one random frame: mostly well-formed, some control words and noise
   task automatic send_random_frame();
      int         pick;
      int         len;
      logic [7:0] sum;
      logic [7:0] b;
      pick = $urandom_range(99);
      sum  = '0;
      if (pick < 70) begin
         pick = $urandom_range(99);
         if (pick < 85)
            len = $urandom_range(8, 1);
         else if (pick < 95)
            len = $urandom_range(35, 9);
         else
            len = $urandom_range(38, 36);
         for (int i = 0; i < len; i++) begin
            b = 8'($urandom_range(255));
            sum = sum + b;
            send_beat(mdbrd_pkg::REQ_WORD, {1'b0, b});
         end
         pick = $urandom_range(99);
         if (pick < 75)
            send_beat(mdbrd_pkg::REQ_WORD, {1'b1, sum});
         else if (pick < 85)
            send_beat(mdbrd_pkg::REQ_WORD, {1'b1, sum ^ 8'($urandom_range(255, 1))});
         else if (pick < 92)
            send_beat(mdbrd_pkg::REQ_TIMEOUT, 9'($urandom_range(511)));
         else
            send_beat(mdbrd_pkg::REQ_LINE_ERR, 9'($urandom_range(511)));
      end else if (pick < 82) begin
         pick = $urandom_range(2);
         if (pick == 0)
            send_beat(mdbrd_pkg::REQ_WORD, ack_word);
         else if (pick == 1)
            send_beat(mdbrd_pkg::REQ_WORD, nak_word);
         else
            send_beat(mdbrd_pkg::REQ_WORD, {1'b1, 8'($urandom_range(255))});
      end else begin
         send_beat(2'($urandom_range(3)), 9'($urandom_range(511)));
      end
   endtask

   // reset values of the code registers, the three control classes, a timeout, a line error and an ignored beat
   task automatic test_reset_codes();
      csr_check(ADDR_ACK, mdbrd_pkg::ACK_CODE_RESET);
      csr_check(ADDR_NAK, mdbrd_pkg::NAK_CODE_RESET);
      send_beat(mdbrd_pkg::REQ_WORD, mdbrd_pkg::ACK_CODE_RESET);
      send_beat(mdbrd_pkg::REQ_WORD, mdbrd_pkg::NAK_CODE_RESET);
      send_beat(mdbrd_pkg::REQ_WORD, 9'h1AB);
      send_beat(mdbrd_pkg::REQ_TIMEOUT, 9'h000);
      send_beat(mdbrd_pkg::REQ_LINE_ERR, 9'h1FF);
      send_beat(REQ_UNUSED, 9'h155);
      wait_idle();
   endtask

   // checksum match and mismatch, aborts, timeouts, ignored beats
   task automatic test_frame_endings();
      send_beat(mdbrd_pkg::REQ_WORD, 9'h000);
      send_beat(mdbrd_pkg::REQ_WORD, 9'h0FF);
      send_beat(mdbrd_pkg::REQ_WORD, 9'h080);
      send_beat(mdbrd_pkg::REQ_WORD, 9'h17F);
      send_beat(mdbrd_pkg::REQ_WORD, 9'h055);
      send_beat(mdbrd_pkg::REQ_WORD, 9'h1AA);
      send_beat(mdbrd_pkg::REQ_WORD, 9'h012);
      send_beat(REQ_UNUSED, 9'h1FF);
      send_beat(mdbrd_pkg::REQ_WORD, 9'h034);
      send_beat(mdbrd_pkg::REQ_TIMEOUT, 9'h0AA);
      send_beat(mdbrd_pkg::REQ_WORD, 9'h001);
      send_beat(mdbrd_pkg::REQ_LINE_ERR, 9'h000);
      // checksum of an empty frame is still classified
      send_beat(mdbrd_pkg::REQ_WORD, 9'h100);
      send_beat(REQ_UNUSED, 9'h000);
      send_beat(mdbrd_pkg::REQ_TIMEOUT, 9'h1FF);
      wait_idle();
   endtask

   // full buffer ending normally, then one byte too many
   task automatic test_overflow();
      logic [7:0] sum;
      sum = '0;
      for (int i = 0; i < MAX_BYTES; i++) begin
         sum = sum + 8'(i * 7 + 3);
         send_beat(mdbrd_pkg::REQ_WORD, {1'b0, 8'(i * 7 + 3)});
      end
      send_beat(mdbrd_pkg::REQ_WORD, {1'b1, sum});
      for (int i = 0; i <= MAX_BYTES; i++)
         send_beat(mdbrd_pkg::REQ_WORD, {1'b0, 8'(255 - i)});
      send_beat(REQ_UNUSED, 9'h0C3);
      send_beat(mdbrd_pkg::REQ_WORD, 9'h0C3);
      send_beat(mdbrd_pkg::REQ_TIMEOUT, 9'h000);
      wait_idle();
   endtask

   // code register settings, extremes and equal codes among them
   task automatic test_code_settings();
      logic [8:0] acks[5];
      logic [8:0] naks[5];
      acks = '{9'h000, 9'h1FF, 9'h1FF, 9'h123, 9'h155};
      naks = '{9'h000, 9'h1FF, 9'h100, 9'h0AA, 9'h155};
      for (int i = 0; i < 5; i++) begin
         set_codes(acks[i], naks[i]);
         send_beat(mdbrd_pkg::REQ_WORD, {1'b1, acks[i][7:0]});
         send_beat(mdbrd_pkg::REQ_WORD, {1'b1, naks[i][7:0]});
         send_beat(mdbrd_pkg::REQ_WORD, ack_word);
         send_beat(mdbrd_pkg::REQ_WORD, nak_word);
         send_beat(mdbrd_pkg::REQ_WORD, 9'h1C3);
      end
      wait_idle();
   endtask

   // random frames under one idling mix, codes changed first
   task automatic test_random_phase(input int req_pct, input int rsp_pct);
      logic [8:0] ack;
      logic [8:0] nak;
      int         target;
      ack = ($urandom_range(99) < 85) ? {1'b1, 8'($urandom_range(255))}
                                      : 9'($urandom_range(511));
      nak = ($urandom_range(99) < 20) ? ack : 9'($urandom_range(511));
      set_codes(ack, nak);
      req_idle_pct = req_pct;
      rsp_idle_pct = rsp_pct;
      target = beats_sent + PHASE_BEATS;
      while (beats_sent < target)
         send_random_frame();
      wait_idle();
   endtask

   // long result-side hold-off while requests keep coming
   task automatic test_backpressure();
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      hold_len     = 80;
      hold_token   = hold_token + 1;
      for (int i = 0; i < 6; i++)
         send_random_frame();
      wait_idle();
   endtask

   initial begin
      reset       <= 1'b1;
      psel        <= 1'b0;
      penable     <= 1'b0;
      pwrite      <= 1'b0;
      paddr       <= '0;
      pwdata      <= '0;
      req_valid   <= 1'b0;
      req_type    <= mdbrd_pkg::REQ_WORD;
      req_rx_word <= '0;
      rsp_stall   <= 1'b0;
      ack_word    = mdbrd_pkg::ACK_CODE_RESET;
      nak_word    = mdbrd_pkg::NAK_CODE_RESET;
      frame_sum   = '0;
      frame_count = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_codes();
      test_frame_endings();
      test_overflow();
      test_code_settings();
      test_backpressure();
      test_random_phase(38, 51);
      test_random_phase(51, 38);
      test_random_phase(0, 0);

      // drain, then wait for any stray response
      rsp_idle_pct = 0;
      wait_idle();
      repeat (5) @(posedge clock);
      if (error_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
